// ===== hw/rtl/tmadc_pkg.sv =====
`default_nettype none
package tmadc_pkg;

   localparam int WINDOW     = 6;
   localparam int SAMPLE_W   = 16;
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW) + 1;
   localparam int AVG_W      = 16;
   localparam int CHG_W      = 17;
   localparam int GAIN_W     = 18;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_W      = GAIN_W;

   localparam int RAW_SHIFT  = 20;
   localparam int RAW_W      = 42;
   localparam int DUTY_W     = RAW_W - RAW_SHIFT;

   // floor(u/n) == (u*RECIP[n]) >> RECIP_SHIFT exactly for u < 2^SUM_W, n <= 16
   localparam int RECIP_SHIFT = SUM_W + 4;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_IDX_W = 5;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [17] = '{
      RECIP_W'(0),
      RECIP_W'(((2**RECIP_SHIFT) + 0) / 1),
      RECIP_W'(((2**RECIP_SHIFT) + 1) / 2),
      RECIP_W'(((2**RECIP_SHIFT) + 2) / 3),
      RECIP_W'(((2**RECIP_SHIFT) + 3) / 4),
      RECIP_W'(((2**RECIP_SHIFT) + 4) / 5),
      RECIP_W'(((2**RECIP_SHIFT) + 5) / 6),
      RECIP_W'(((2**RECIP_SHIFT) + 6) / 7),
      RECIP_W'(((2**RECIP_SHIFT) + 7) / 8),
      RECIP_W'(((2**RECIP_SHIFT) + 8) / 9),
      RECIP_W'(((2**RECIP_SHIFT) + 9) / 10),
      RECIP_W'(((2**RECIP_SHIFT) + 10) / 11),
      RECIP_W'(((2**RECIP_SHIFT) + 11) / 12),
      RECIP_W'(((2**RECIP_SHIFT) + 12) / 13),
      RECIP_W'(((2**RECIP_SHIFT) + 13) / 14),
      RECIP_W'(((2**RECIP_SHIFT) + 14) / 15),
      RECIP_W'(((2**RECIP_SHIFT) + 15) / 16)
   };

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DELTA   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL_DUTY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DUTY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY     = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_DELTA_RST   = 18'd153600;
   localparam logic [GAIN_W-1:0] GAIN_LEVEL_RST   = 18'd3657;
   localparam logic [PCT_W-1:0]  NOMINAL_DUTY_RST = 7'd60;
   localparam logic [PCT_W-1:0]  MIN_DUTY_RST     = 7'd40;
   localparam logic [PCT_W-1:0]  MAX_DUTY_RST     = 7'd100;

   typedef struct packed {
      logic                       en;
      logic [SLOT_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] data;
   } ring_wr_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SUM  = 8'b0000_0010,
      S_DIV  = 8'b0000_0100,
      S_MUL  = 8'b0000_1000,
      S_AVG  = 8'b0001_0000,
      S_PROD = 8'b0010_0000,
      S_RAW  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tmadc_req_if.sv =====
`default_nettype none
interface tmadc_req_if
   import tmadc_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] tilt_sample;

   modport source (output valid, output tilt_sample, input ready);
   modport sink   (input valid, input tilt_sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tmadc_rsp_if.sv =====
`default_nettype none
interface tmadc_rsp_if
   import tmadc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] duty_percent;
   logic             clamped;

   modport source (output valid, output duty_percent, output clamped, input ready);
   modport sink   (input valid, input duty_percent, input clamped, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tmadc_ring.sv =====
`default_nettype none
module tmadc_ring
   import tmadc_pkg::*;
(
   input  wire logic                       clock,
   input  wire ring_wr_type                wr,
   input  wire logic [SLOT_W-1:0]          rd_addr,
   output logic signed [SAMPLE_W-1:0]      rd_data
);

   logic signed [SAMPLE_W-1:0] mem_ff [WINDOW];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tilt_moving_average_duty_control.sv =====
// Tilt moving-average duty controller.
// req_chan carries one signed tilt sample (1/4096 g) per item; rsp_chan returns
// one item per sample: the clamped wheel duty percent and a clamp flag.
// Both channels use valid/ready; an item moves when both are high.
// The csr_ port writes the gain, nominal and clamp registers; write only
// while the block is idle.
// One item is in work at a time; a new sample is accepted only while the
// block is idle. The sample ring is a synchronous RAM with a registered
// read, read ahead of the sum update; the average is a reciprocal
// multiply and the duty sums the nominal value and two gain products.
// If rsp_chan stalls, the finished item waits in the output register; the
// next sample is still accepted and its work halts at the last step until
// the output register frees.
// Reset (synchronous, active high) clears the sum, average, change, fill
// count and ring pointer and loads the default register values. The ring
// contents need no clearing: a slot is written before it is ever read.
`default_nettype none
module tilt_moving_average_duty_control
   import tmadc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   tmadc_req_if.sink                 req_chan,
   tmadc_rsp_if.source               rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   logic [GAIN_W-1:0] gain_delta_ff, gain_level_ff;
   logic [PCT_W-1:0]  nominal_ff, min_ff, max_ff;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       full_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [SLOT_W-1:0]          oldest_ff;
   logic [CNT_W-1:0]           n_ff;
   logic                       neg_ff;
   logic [SUM_W-1:0]           u_ff;
   logic [RECIP_W-1:0]         recip_ff;
   logic [SUM_W-1:0]           q_ff;
   logic signed [AVG_W-1:0]    avg_ff;
   logic signed [CHG_W-1:0]    chg_ff;
   logic signed [CHG_W+GAIN_W:0] pd_ff;
   logic signed [AVG_W+GAIN_W:0] pl_ff;
   logic signed [DUTY_W-1:0]   duty_ff;

   logic             rsp_valid_ff;
   logic [PCT_W-1:0] rsp_duty_ff;
   logic             rsp_clamped_ff;

   ring_wr_type                ring_wr;
   logic signed [SAMPLE_W-1:0] ring_rd;

   logic                       accept;
   logic                       out_free;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic [SUM_W+RECIP_W-1:0]   prod;
   logic signed [AVG_W-1:0]    avg_new;
   logic signed [RAW_W-1:0]    raw;
   logic signed [DUTY_W-1:0]   max_ext, min_ext;

   tmadc_ring u_ring (
      .clock   (clock),
      .wr      (ring_wr),
      .rd_addr (oldest_ff),
      .rd_data (ring_rd)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.duty_percent = rsp_duty_ff;
   assign rsp_chan.clamped      = rsp_clamped_ff;

   assign old_sample = full_ff ? ring_rd : '0;
   assign prod       = SUM_W'(u_ff) * RECIP_W'(recip_ff);
   assign avg_new    = neg_ff ? AVG_W'(SUM_W'(0) - q_ff) : AVG_W'(q_ff);
   assign raw        = RAW_W'({nominal_ff, RAW_SHIFT'(0)}) + RAW_W'(pd_ff) + RAW_W'(pl_ff);
   assign max_ext    = DUTY_W'({1'b0, max_ff});
   assign min_ext    = DUTY_W'({1'b0, min_ff});

   always_comb begin
      ring_wr.en   = (state_ff == S_SUM);
      ring_wr.addr = full_ff ? oldest_ff : SLOT_W'(fill_ff);
      ring_wr.data = sample_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_SUM;
         S_SUM:  state_in = S_DIV;
         S_DIV:  state_in = S_MUL;
         S_MUL:  state_in = S_AVG;
         S_AVG:  state_in = S_PROD;
         S_PROD: state_in = S_RAW;
         S_RAW:  state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gain_delta_ff <= GAIN_DELTA_RST;
         gain_level_ff <= GAIN_LEVEL_RST;
         nominal_ff    <= NOMINAL_DUTY_RST;
         min_ff        <= MIN_DUTY_RST;
         max_ff        <= MAX_DUTY_RST;
         sum_ff        <= '0;
         fill_ff       <= '0;
         oldest_ff     <= '0;
         avg_ff        <= '0;
         chg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_index)
               REG_GAIN_DELTA:   gain_delta_ff <= csr_wdata[GAIN_W-1:0];
               REG_GAIN_LEVEL:   gain_level_ff <= csr_wdata[GAIN_W-1:0];
               REG_NOMINAL_DUTY: nominal_ff    <= csr_wdata[PCT_W-1:0];
               REG_MIN_DUTY:     min_ff        <= csr_wdata[PCT_W-1:0];
               REG_MAX_DUTY:     max_ff        <= csr_wdata[PCT_W-1:0];
               default: ;
            endcase
         end

         if (state_ff == S_SUM) begin
            sum_ff <= sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
            if (full_ff) begin
               oldest_ff <= (oldest_ff == SLOT_W'(WINDOW - 1)) ? '0 : oldest_ff + 1'b1;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end

         if (state_ff == S_AVG) begin
            avg_ff <= avg_new;
            if (full_ff) begin
               chg_ff <= CHG_W'(avg_new) - CHG_W'(avg_ff);
            end
         end

         rsp_valid_ff <= (state_ff == S_OUT && out_free) || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept) begin
         sample_ff <= req_chan.tilt_sample;
         full_ff   <= (fill_ff == CNT_W'(WINDOW));
      end
      if (state_ff == S_SUM) begin
         n_ff <= full_ff ? CNT_W'(WINDOW) : fill_ff + 1'b1;
      end
      if (state_ff == S_DIV) begin
         neg_ff   <= sum_ff[SUM_W-1];
         u_ff     <= sum_ff[SUM_W-1]
                   ? SUM_W'(SUM_W'(0) - sum_ff) + SUM_W'(n_ff) - SUM_W'(1)
                   : SUM_W'(sum_ff);
         recip_ff <= RECIP_TABLE[RECIP_IDX_W'(n_ff)];
      end
      if (state_ff == S_MUL) begin
         q_ff <= prod[RECIP_SHIFT +: SUM_W];
      end
      if (state_ff == S_PROD) begin
         pd_ff <= chg_ff * $signed({1'b0, gain_delta_ff});
         pl_ff <= avg_ff * $signed({1'b0, gain_level_ff});
      end
      if (state_ff == S_RAW) begin
         duty_ff <= raw[RAW_W-1:RAW_SHIFT];
      end
      if (state_ff == S_OUT && out_free) begin
         if (duty_ff > max_ext) begin
            rsp_duty_ff    <= max_ff;
            rsp_clamped_ff <= 1'b1;
         end else if (duty_ff < min_ext) begin
            rsp_duty_ff    <= min_ff;
            rsp_clamped_ff <= 1'b1;
         end else begin
            rsp_duty_ff    <= duty_ff[PCT_W-1:0];
            rsp_clamped_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire
